>>> hdl/pgbi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the pebble game bond insert block
// no dependencies; imported by pgbi_engine and the top level

package pgbi_pkg;

  localparam int SITES_DEF = 1024;
  localparam int SITE_W    = 10;
  localparam int EPOCH_W   = 8;
  localparam int ICNT_W    = 11;
  localparam int RCNT_W    = 16;

  localparam logic             REQ_ADD   = 1'b0;
  localparam logic             REQ_CLEAR = 1'b1;
  localparam logic [1:0]       PEB_FULL  = 2'd2;
  localparam logic [1:0]       PEB_ONE   = 2'd1;
  localparam logic [1:0]       PEB_NONE  = 2'd0;
  localparam logic [RCNT_W-1:0] RED_MAX  = {RCNT_W{1'b1}};

  typedef struct packed {
    logic              req_type;
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
  } req_t;

  typedef struct packed {
    logic              independent;
    logic [ICNT_W-1:0] independent_count;
    logic [RCNT_W-1:0] redundant_count;
    logic [1:0]        pebbles_a;
    logic [1:0]        pebbles_b;
  } res_t;

endpackage

>>> hdl/pgbi_engine.sv
`timescale 1ns / 1ps
// pebble search and path reversal sequencer around the site memory and path stack
// depends on pgbi_pkg

module pgbi_engine
  import pgbi_pkg::*;
#(
  parameter int SITES = SITES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  output logic req_ready,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  localparam int SW = $clog2(SITES);
  localparam int WW = EPOCH_W + 2 * (SW + 1);
  localparam int BW = SW + 1;
  localparam int EDGE_LIMIT = 2 * SITES - 3;
  localparam int V0 = SW;
  localparam int V1 = 2 * SW + 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK_RD, S_CHK, S_SCRUB, S_SKIP_RD, S_SKIP_MK, S_ROOT_RD,
    S_ROOT_MK, S_EXPAND, S_CAND, S_POP, S_POP_EDGE, S_POP_LD, S_REV_STK,
    S_REV_EDGE, S_REV_WR, S_FIN_A, S_FIN_B, S_FIN_C, S_DONE
  } state_t;

  // site word: slot0 low, slot1 above it, visit epoch on top
  function automatic logic [WW-1:0] slot_put(input logic [WW-1:0] w, input logic [SW-1:0] to);
    logic [WW-1:0] r;
    r = w;
    if (!w[V0]) begin
      r[SW:0] = {1'b1, to};
    end else if (!w[V1]) begin
      r[2*SW+1:SW+1] = {1'b1, to};
    end
    return r;
  endfunction

  function automatic logic [WW-1:0] slot_drop(input logic [WW-1:0] w, input logic [SW-1:0] to);
    logic [WW-1:0] r;
    r = w;
    if (w[V0] && (w[SW-1:0] == to)) begin
      r[SW:0]        = w[2*SW+1:SW+1];
      r[2*SW+1:SW+1] = '0;
    end else if (w[V1] && (w[2*SW:SW+1] == to)) begin
      r[2*SW+1:SW+1] = '0;
    end
    return r;
  endfunction

  function automatic logic [1:0] peb(input logic [WW-1:0] w);
    logic [1:0] r;
    if (!w[V0]) r = PEB_FULL;
    else if (!w[V1]) r = PEB_ONE;
    else r = PEB_NONE;
    return r;
  endfunction

  function automatic logic [WW-1:0] mark(input logic [WW-1:0] w, input logic [EPOCH_W-1:0] e);
    return {e, w[2*SW+1:0]};
  endfunction

  // memories
  logic [WW-1:0] emem [SITES];
  logic [SW-1:0] smem [SITES];
  logic          e_we, st_we;
  logic [SW-1:0] e_waddr, e_raddr, st_waddr, st_raddr, st_wdata, st_rdata_r;
  logic [WW-1:0] e_wdata, e_rdata_r;

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
    e_rdata_r <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      smem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= smem[st_raddr];
  end

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;   // 0 gathering onto b, 1 onto a
  logic [SW-1:0]     site_a_r, site_a_nxt, site_b_r, site_b_nxt;
  logic              a_ok_r, a_ok_nxt, b_ok_r, b_ok_nxt, run_r, run_nxt;
  logic              clr_req_r, clr_req_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SW:0]       scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [SW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [WW-1:0]     here_word_r, here_word_nxt;
  logic              kidx_r, kidx_nxt;
  logic [SW:0]       depth_r, depth_nxt;
  logic [SW-1:0]     cand_site_r, cand_site_nxt, cur_site_r, cur_site_nxt;
  logic [SW-1:0]     prev_site_r, prev_site_nxt;
  logic [WW-1:0]     cur_word_r, cur_word_nxt, a_word_r, a_word_nxt;
  logic [BW-1:0]     bond_r, bond_nxt;
  logic [RCNT_W-1:0] red_r, red_nxt;
  logic              res_ind_r, res_ind_nxt;
  logic [1:0]        res_pa_r, res_pa_nxt, res_pb_r, res_pb_nxt;

  logic [SW+SITE_W-1:0] a_ext, b_ext;
  logic [SW-1:0]        in_a, in_b, root_site, slot_site;
  logic                 in_a_ok, in_b_ok, slot_valid, fin_ok;
  logic [SW:0]          depth_m2;
  logic [1:0]           pa_now, pb_now;
  logic [BW+ICNT_W-1:0] bond_ext;

  assign a_ext      = {{SW{1'b0}}, req.site_a};
  assign b_ext      = {{SW{1'b0}}, req.site_b};
  assign in_a       = a_ext[SW-1:0];
  assign in_b       = b_ext[SW-1:0];
  assign in_a_ok    = a_ext < (SW+SITE_W)'(SITES);
  assign in_b_ok    = b_ext < (SW+SITE_W)'(SITES);
  assign root_site  = mode_r ? site_a_r : site_b_r;
  assign slot_valid = kidx_r ? here_word_r[V1] : here_word_r[V0];
  assign slot_site  = kidx_r ? here_word_r[2*SW:SW+1] : here_word_r[SW-1:0];
  assign depth_m2   = depth_r - (SW+1)'(2);
  assign pa_now     = peb(a_word_r);
  assign pb_now     = peb(e_rdata_r);
  assign fin_ok     = run_r && (pa_now == PEB_FULL) && (pb_now == PEB_FULL);
  assign bond_ext   = {{ICNT_W{1'b0}}, bond_r};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    site_a_nxt    = site_a_r;
    site_b_nxt    = site_b_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    run_nxt       = run_r;
    clr_req_nxt   = clr_req_r;
    epoch_nxt     = epoch_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    here_word_nxt = here_word_r;
    kidx_nxt      = kidx_r;
    depth_nxt     = depth_r;
    cand_site_nxt = cand_site_r;
    cur_site_nxt  = cur_site_r;
    cur_word_nxt  = cur_word_r;
    prev_site_nxt = prev_site_r;
    a_word_nxt    = a_word_r;
    bond_nxt      = bond_r;
    red_nxt       = red_r;
    res_ind_nxt   = res_ind_r;
    res_pa_nxt    = res_pa_r;
    res_pb_nxt    = res_pb_r;
    e_we     = 1'b0;
    e_waddr  = '0;
    e_wdata  = '0;
    e_raddr  = '0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;

    case (state_r)
      S_CLR: begin
        e_we     = 1'b1;
        e_waddr  = scan_r[SW-1:0];
        scan_nxt = scan_r + 1'b1;
        if (scan_r == (SW+1)'(SITES - 1)) begin
          if (clr_req_r) begin
            res_ind_nxt = 1'b0;
            res_pa_nxt  = a_ok_r ? PEB_FULL : PEB_NONE;
            res_pb_nxt  = b_ok_r ? PEB_FULL : PEB_NONE;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          site_a_nxt = in_a;
          site_b_nxt = in_b;
          a_ok_nxt   = in_a_ok;
          b_ok_nxt   = in_b_ok;
          if (req.req_type == REQ_CLEAR) begin
            clr_req_nxt = 1'b1;
            scan_nxt    = '0;
            epoch_nxt   = '0;
            bond_nxt    = '0;
            red_nxt     = '0;
            state_nxt   = S_CLR;
          end else begin
            run_nxt  = in_a_ok && in_b_ok && (in_a != in_b) &&
                       (bond_r < BW'(EDGE_LIMIT));
            mode_nxt = 1'b0;
            state_nxt = (in_a_ok && in_b_ok && (in_a != in_b) &&
                         (bond_r < BW'(EDGE_LIMIT))) ? S_CHK_RD : S_FIN_A;
          end
        end
      end
      S_CHK_RD: begin
        e_raddr   = root_site;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (e_rdata_r[V0]) begin
          if (epoch_r == {EPOCH_W{1'b1}}) begin
            scan_nxt  = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCRUB;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
            state_nxt = mode_r ? S_SKIP_RD : S_ROOT_RD;
          end
        end else if (!mode_r) begin
          mode_nxt  = 1'b1;
          state_nxt = S_CHK_RD;
        end else begin
          state_nxt = S_FIN_A;
        end
      end
      S_SCRUB: begin
        // epoch wrap: zero every visit mark, one read ahead of the write
        if (pend_r) begin
          e_we    = 1'b1;
          e_waddr = pend_addr_r;
          e_wdata = mark(e_rdata_r, '0);
        end
        if (scan_r != (SW+1)'(SITES)) begin
          e_raddr       = scan_r[SW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_r[SW-1:0];
          scan_nxt      = scan_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          epoch_nxt = {{(EPOCH_W-1){1'b0}}, 1'b1};
          state_nxt = mode_r ? S_SKIP_RD : S_ROOT_RD;
        end
      end
      S_SKIP_RD: begin
        e_raddr   = site_b_r;
        state_nxt = S_SKIP_MK;
      end
      S_SKIP_MK: begin
        e_we      = 1'b1;
        e_waddr   = site_b_r;
        e_wdata   = mark(e_rdata_r, epoch_r);
        state_nxt = S_ROOT_RD;
      end
      S_ROOT_RD: begin
        e_raddr   = root_site;
        state_nxt = S_ROOT_MK;
      end
      S_ROOT_MK: begin
        e_we          = 1'b1;
        e_waddr       = root_site;
        e_wdata       = mark(e_rdata_r, epoch_r);
        here_word_nxt = mark(e_rdata_r, epoch_r);
        st_we         = 1'b1;
        st_waddr      = '0;
        st_wdata      = root_site;
        depth_nxt     = (SW+1)'(1);
        kidx_nxt      = 1'b0;
        state_nxt     = S_EXPAND;
      end
      S_EXPAND: begin
        if (slot_valid) begin
          e_raddr       = slot_site;
          cand_site_nxt = slot_site;
          state_nxt     = S_CAND;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_CAND: begin
        if (e_rdata_r[WW-1:2*SW+2] == epoch_r) begin
          if (!kidx_r) begin
            kidx_nxt  = 1'b1;
            state_nxt = S_EXPAND;
          end else begin
            state_nxt = S_POP;
          end
        end else begin
          st_we     = 1'b1;
          st_waddr  = depth_r[SW-1:0];
          st_wdata  = cand_site_r;
          depth_nxt = depth_r + 1'b1;
          if (!e_rdata_r[V1]) begin
            // free pebble found at the end of the path
            cur_site_nxt = cand_site_r;
            cur_word_nxt = e_rdata_r;
            state_nxt    = S_REV_STK;
          end else begin
            e_we          = 1'b1;
            e_waddr       = cand_site_r;
            e_wdata       = mark(e_rdata_r, epoch_r);
            here_word_nxt = mark(e_rdata_r, epoch_r);
            kidx_nxt      = 1'b0;
            state_nxt     = S_EXPAND;
          end
        end
      end
      S_POP: begin
        depth_nxt = depth_r - 1'b1;
        if (depth_r == (SW+1)'(1)) begin
          // search failed
          if (!mode_r) begin
            mode_nxt  = 1'b1;
            state_nxt = S_CHK_RD;
          end else begin
            state_nxt = S_FIN_A;
          end
        end else begin
          st_raddr  = depth_m2[SW-1:0];
          state_nxt = S_POP_EDGE;
        end
      end
      S_POP_EDGE: begin
        e_raddr   = st_rdata_r;
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        here_word_nxt = e_rdata_r;
        kidx_nxt      = 1'b0;
        state_nxt     = S_EXPAND;
      end
      S_REV_STK: begin
        if (depth_r == (SW+1)'(1)) begin
          e_we      = 1'b1;
          e_waddr   = cur_site_r;
          e_wdata   = cur_word_r;
          depth_nxt = '0;
          mode_nxt  = 1'b0;
          state_nxt = S_CHK_RD;
        end else begin
          st_raddr  = depth_m2[SW-1:0];
          state_nxt = S_REV_EDGE;
        end
      end
      S_REV_EDGE: begin
        e_raddr       = st_rdata_r;
        prev_site_nxt = st_rdata_r;
        state_nxt     = S_REV_WR;
      end
      S_REV_WR: begin
        e_we         = 1'b1;
        e_waddr      = cur_site_r;
        e_wdata      = slot_put(cur_word_r, prev_site_r);
        cur_site_nxt = prev_site_r;
        cur_word_nxt = slot_drop(e_rdata_r, cur_site_r);
        depth_nxt    = depth_r - 1'b1;
        state_nxt    = S_REV_STK;
      end
      S_FIN_A: begin
        e_raddr   = site_a_r;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        a_word_nxt = e_rdata_r;
        e_raddr    = site_b_r;
        state_nxt  = S_FIN_C;
      end
      S_FIN_C: begin
        if (fin_ok) begin
          e_we        = 1'b1;
          e_waddr     = site_a_r;
          e_wdata     = slot_put(a_word_r, site_b_r);
          bond_nxt    = bond_r + 1'b1;
          res_ind_nxt = 1'b1;
          res_pa_nxt  = a_ok_r ? PEB_ONE : PEB_NONE;
        end else begin
          res_ind_nxt = 1'b0;
          res_pa_nxt  = a_ok_r ? pa_now : PEB_NONE;
          if (red_r != RED_MAX) begin
            red_nxt = red_r + 1'b1;
          end
        end
        res_pb_nxt = b_ok_r ? pb_now : PEB_NONE;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          clr_req_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      scan_r    <= '0;
      clr_req_r <= 1'b0;
      epoch_r   <= '0;
      pend_r    <= 1'b0;
      depth_r   <= '0;
      bond_r    <= '0;
      red_r     <= '0;
      mode_r    <= 1'b0;
      run_r     <= 1'b0;
      kidx_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_r    <= scan_nxt;
      clr_req_r <= clr_req_nxt;
      epoch_r   <= epoch_nxt;
      pend_r    <= pend_nxt;
      depth_r   <= depth_nxt;
      bond_r    <= bond_nxt;
      red_r     <= red_nxt;
      mode_r    <= mode_nxt;
      run_r     <= run_nxt;
      kidx_r    <= kidx_nxt;
    end
    site_a_r    <= site_a_nxt;
    site_b_r    <= site_b_nxt;
    a_ok_r      <= a_ok_nxt;
    b_ok_r      <= b_ok_nxt;
    pend_addr_r <= pend_addr_nxt;
    here_word_r <= here_word_nxt;
    cand_site_r <= cand_site_nxt;
    cur_site_r  <= cur_site_nxt;
    cur_word_r  <= cur_word_nxt;
    prev_site_r <= prev_site_nxt;
    a_word_r    <= a_word_nxt;
    res_ind_r   <= res_ind_nxt;
    res_pa_r    <= res_pa_nxt;
    res_pb_r    <= res_pb_nxt;
  end

  assign req_ready             = (state_r == S_IDLE);
  assign res_valid             = (state_r == S_DONE);
  assign res.independent       = res_ind_r;
  assign res.independent_count = bond_ext[ICNT_W-1:0];
  assign res.redundant_count   = red_r;
  assign res.pebbles_a         = res_pa_r;
  assign res.pebbles_b         = res_pb_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= (SW+1)'(SITES))
    else $error("path stack deeper than the site count");

  a_bond_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bond_r <= BW'(EDGE_LIMIT))
    else $error("independent bond count above limit");

  a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
    e_we |-> (!e_wdata[V1] || e_wdata[V0]))
    else $error("second edge slot written without the first");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_C && fin_ok) |=> (bond_r == $past(bond_r) + 1'b1) && res_ind_r)
    else $error("inserted bond not counted");

endmodule

>>> hdl/pebble_game_bond_insert.sv
`timescale 1ns / 1ps
// top level of the pebble game bond insert block: stream ports and result register
// depends on pgbi_pkg and pgbi_engine
//
//  channel   | dir | contents
//  in_*      | in  | tuser request kind, tdata site pair
//  out_*     | out | tdata verdict, counts and pebbles of both sites
//
// one request at a time; an add request runs depth-first searches of the site
// memory for free pebbles and reverses each path it finds, site by site. a clear
// request sweeps the whole site memory, and every 255th search adds a sweep that
// resets the visit marks.
// after reset a sweep clears the site memory with in_tready low.
// a new request is taken while a finished result still waits on out_tready.

module pebble_game_bond_insert
  import pgbi_pkg::*;
#(
  parameter int SITES = SITES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // site_a[9:0], site_b[19:10], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // independent, independent_count, redundant_count,
                                  // pebbles_a, pebbles_b
);

  req_t req;
  res_t res, out_r;
  logic eng_ready, res_valid, res_take, out_valid_r;

  assign req.req_type = in_tuser;
  assign req.site_a   = in_tdata[SITE_W-1:0];
  assign req.site_b   = in_tdata[2*SITE_W-1:SITE_W];

  pgbi_engine #(
    .SITES (SITES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (eng_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_take)
  );

  // result register frees as soon as the current transfer completes
  assign res_take  = !out_valid_r || out_tready;
  assign in_tready = eng_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.pebbles_b, out_r.pebbles_a, out_r.redundant_count,
                       out_r.independent_count, out_r.independent};

endmodule
